// File: rtl/core/edf_periodic_task_scheduler_core_macros.svh
// assertion macros used by the scheduler checker
// no dependencies; take in with `include before use
`ifndef EDF_PERIODIC_TASK_SCHEDULER_CORE_MACROS_SVH
`define EDF_PERIODIC_TASK_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication, reset disables
`define EDFS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, reset disables
`define EDFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/edfs_pkg.sv
// types and constants of the edf periodic task scheduler
// no dependencies; used by the core, the task ram user and the checker
package edfs_pkg;

   localparam int TASKS    = 8;
   localparam int IDX_W    = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam int CNT_W    = $clog2(TASKS + 1);
   localparam int EXEC_W   = 16;
   localparam int PERIOD_W = 16;
   localparam int TIME_W   = 32;
   localparam int REQ_IDX_W = 3;

   typedef enum logic [1:0] {
      KIND_RUN  = 2'd0,
      KIND_IDLE = 2'd1,
      KIND_MISS = 2'd2
   } kind_type;

   typedef enum logic {
      MODE_TICK = 1'b0,
      MODE_LOAD = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PASS,
      ST_FIX,
      ST_MISS
   } state_type;

   // one task table entry as held in the task ram
   typedef struct packed {
      logic [EXEC_W-1:0]   exec;
      logic [PERIOD_W-1:0] period;
      logic [EXEC_W-1:0]   rem;
      logic [TIME_W-1:0]   rel_tick;
      logic [TIME_W-1:0]   deadline;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// File: rtl/core/edfs_ram.sv
// generic single-write, single-read synchronous ram, registered read data
// no dependencies
module edfs_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/edf_periodic_task_scheduler_core.sv
// A load beat writes one task entry and leaves busy low. A tick beat keeps busy high
// while the task table, which sits in one ram with a single read port, is walked one
// entry per cycle and while the results are produced: the run or idle result and then
// each miss result appear on consecutive cycles, one cycle each, since the receiver
// cannot stall. Entries of tasks never loaded are never used, so no clearing pass runs
// after reset.
// depends on edfs_pkg and edfs_ram
module edf_periodic_task_scheduler_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_mode,
   input  logic [edfs_pkg::REQ_IDX_W-1:0] req_task_index,
   input  logic [edfs_pkg::EXEC_W-1:0]    req_exec_time,
   input  logic [edfs_pkg::PERIOD_W-1:0]  req_period,
   input  logic [edfs_pkg::PERIOD_W-1:0]  req_arrival,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_kind,
   output logic [2:0]                     rsp_task_index_res,
   output logic [edfs_pkg::TIME_W-1:0]    rsp_time_stamp,
   output logic                           rsp_last
);

   localparam int TASKS = edfs_pkg::TASKS;
   localparam int IDX_W = edfs_pkg::IDX_W;
   localparam int CNT_W = edfs_pkg::CNT_W;
   localparam int TW    = edfs_pkg::TIME_W;

   edfs_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [TW-1:0]       now_ff, now_in;
   logic [TASKS-1:0]    loaded_ff, loaded_in;
   logic [TASKS-1:0]    mask_ff, mask_in;
   logic                best_found_ff, best_found_in;
   logic                best_gt1_ff, best_gt1_in;
   logic                best_cand_ff, best_cand_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [TW-1:0]       best_dl_ff, best_dl_in;
   edfs_pkg::entry_type best_entry_ff, best_entry_in;
   edfs_pkg::kind_type  rsp_kind_ff, rsp_kind_in;
   logic [2:0]          rsp_idx_ff, rsp_idx_in;
   logic [TW-1:0]       rsp_ts_ff, rsp_ts_in;
   logic                rsp_last_ff, rsp_last_in;

   // task ram
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   edfs_pkg::entry_type   wr_entry;
   logic [IDX_W-1:0]      rd_addr;
   logic [edfs_pkg::ENTRY_W-1:0] rd_data;

   edfs_ram #(
      .WIDTH (edfs_pkg::ENTRY_W),
      .DEPTH (TASKS)
   ) u_task_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   logic                accept;
   logic                load_ok;
   logic [IDX_W-1:0]    load_idx;
   logic [TW-1:0]       ts;
   logic [TW-1:0]       now_p1;
   logic [CNT_W-1:0]    cnt_dec;
   logic [IDX_W-1:0]    proc_idx;
   logic                proc_on;
   logic                proc_loaded;
   edfs_pkg::entry_type rd_entry;
   edfs_pkg::entry_type upd;
   logic                upd_ready;
   logic                cand;
   logic                take_best;
   logic [TASKS-1:0]    fix_mask;
   logic [TASKS-1:0]    miss_rest;
   logic [IDX_W-1:0]    low_idx;

   assign busy     = (state_ff != edfs_pkg::ST_IDLE);
   assign accept   = start && !busy;
   assign load_ok  = ({29'b0, req_task_index} < 32'(TASKS));
   assign load_idx = IDX_W'(req_task_index);
   assign ts       = (now_ff == '1) ? '1 : now_ff + TW'(1);
   assign now_p1   = now_ff + TW'(1);
   assign cnt_dec  = cnt_ff - CNT_W'(1);
   assign proc_idx = cnt_dec[IDX_W-1:0];
   assign proc_on  = (state_ff == edfs_pkg::ST_PASS) && (cnt_ff != '0);
   assign proc_loaded = loaded_ff[proc_idx];
   assign rd_entry = edfs_pkg::entry_type'(rd_data);
   assign rd_addr  = cnt_ff[IDX_W-1:0];

   // release and evaluate the entry coming out of the ram
   always_comb begin
      upd = rd_entry;
      if (proc_loaded && rd_entry.rel_tick == now_ff) begin
         upd.rem      = rd_entry.exec;
         upd.deadline = now_ff + {16'b0, rd_entry.period};
         upd.rel_tick = now_ff + {16'b0, rd_entry.period};
      end
   end

   assign upd_ready = proc_loaded && (upd.rem != '0);
   // now == deadline - 1, wrapping
   assign cand      = upd_ready && (upd.deadline == now_p1);
   assign take_best = upd_ready && (!best_found_ff || upd.deadline < best_dl_ff);

   // the running task only misses if work is still left after its unit
   always_comb begin
      fix_mask = mask_ff;
      if (best_found_ff && !best_gt1_ff) begin
         fix_mask[best_idx_ff] = 1'b0;
      end
   end

   always_comb begin
      low_idx = '0;
      for (int i = TASKS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            low_idx = IDX_W'(i);
         end
      end
      miss_rest          = mask_ff;
      miss_rest[low_idx] = 1'b0;
   end

   // ram write port
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = proc_idx;
      wr_entry = upd;
      if (cand) begin
         wr_entry.rem = '0;
      end
      priority if (accept && req_mode == edfs_pkg::MODE_LOAD) begin
         wr_en             = load_ok;
         wr_addr           = load_idx;
         wr_entry.exec     = req_exec_time;
         wr_entry.period   = req_period;
         wr_entry.rem      = '0;
         wr_entry.rel_tick = {16'b0, req_arrival};
         wr_entry.deadline = '0;
      end else if (proc_on) begin
         wr_en = proc_loaded;
      end else if (state_ff == edfs_pkg::ST_FIX) begin
         wr_en        = best_found_ff && !best_cand_ff;
         wr_addr      = best_idx_ff;
         wr_entry     = best_entry_ff;
         wr_entry.rem = best_entry_ff.rem - edfs_pkg::EXEC_W'(1);
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      now_in        = now_ff;
      loaded_in     = loaded_ff;
      mask_in       = mask_ff;
      best_found_in = best_found_ff;
      best_gt1_in   = best_gt1_ff;
      best_cand_in  = best_cand_ff;
      best_idx_in   = best_idx_ff;
      best_dl_in    = best_dl_ff;
      best_entry_in = best_entry_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_ts_in     = rsp_ts_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         edfs_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_mode == edfs_pkg::MODE_LOAD) begin
                  if (load_ok) begin
                     loaded_in[load_idx] = 1'b1;
                  end
               end else begin
                  state_in      = edfs_pkg::ST_PASS;
                  cnt_in        = '0;
                  mask_in       = '0;
                  best_found_in = 1'b0;
               end
            end
         end
         edfs_pkg::ST_PASS: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(TASKS)) begin
               state_in = edfs_pkg::ST_FIX;
            end
            if (proc_on) begin
               mask_in[proc_idx] = cand;
               if (take_best) begin
                  best_found_in = 1'b1;
                  best_idx_in   = proc_idx;
                  best_dl_in    = upd.deadline;
                  best_cand_in  = cand;
                  best_gt1_in   = (upd.rem > edfs_pkg::EXEC_W'(1));
                  best_entry_in = upd;
               end
            end
         end
         edfs_pkg::ST_FIX: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = best_found_ff ? edfs_pkg::KIND_RUN : edfs_pkg::KIND_IDLE;
            rsp_idx_in   = best_found_ff ? 3'(best_idx_ff) : 3'd0;
            rsp_ts_in    = ts;
            rsp_last_in  = (fix_mask == '0);
            mask_in      = fix_mask;
            now_in       = ts;
            state_in     = (fix_mask == '0) ? edfs_pkg::ST_IDLE : edfs_pkg::ST_MISS;
         end
         edfs_pkg::ST_MISS: begin
            // time stamp stays from the run or idle beat
            rsp_valid_in = 1'b1;
            rsp_kind_in  = edfs_pkg::KIND_MISS;
            rsp_idx_in   = 3'(low_idx);
            rsp_last_in  = (miss_rest == '0);
            mask_in      = miss_rest;
            if (miss_rest == '0) begin
               state_in = edfs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = edfs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= edfs_pkg::ST_IDLE;
         cnt_ff        <= '0;
         now_ff        <= '0;
         loaded_ff     <= '0;
         mask_ff       <= '0;
         best_found_ff <= 1'b0;
         best_gt1_ff   <= 1'b0;
         best_cand_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         now_ff        <= now_in;
         loaded_ff     <= loaded_in;
         mask_ff       <= mask_in;
         best_found_ff <= best_found_in;
         best_gt1_ff   <= best_gt1_in;
         best_cand_ff  <= best_cand_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff   <= best_idx_in;
      best_dl_ff    <= best_dl_in;
      best_entry_ff <= best_entry_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_ts_ff     <= rsp_ts_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_task_index_res = rsp_idx_ff;
   assign rsp_time_stamp     = rsp_ts_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

// File: rtl/core/edfs_checker.sv
// port-level checks of the scheduler core, bound to the core module
// depends on edfs_pkg and edf_periodic_task_scheduler_core_macros.svh
`include "edf_periodic_task_scheduler_core_macros.svh"

module edfs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           req_mode,
   input logic                           rsp_valid,
   input logic [1:0]                     rsp_kind,
   input logic [2:0]                     rsp_task_index_res,
   input logic                           rsp_last
);

   // a tick beat always occupies the core
   `EDFS_ASSERT_NEXT(a_tick_busy, clock, reset, start && !busy && req_mode == edfs_pkg::MODE_TICK, busy, "tick beat did not raise busy")

   // the results of one tick come back to back
   `EDFS_ASSERT_NEXT(a_burst_gap, clock, reset, rsp_valid && !rsp_last, rsp_valid, "gap inside a result burst")

   `EDFS_ASSERT_NEXT(a_last_ends, clock, reset, rsp_valid && rsp_last, !rsp_valid, "result after the last beat")

   `EDFS_ASSERT_NOW(a_busy_burst, clock, reset, rsp_valid && !rsp_last, busy, "busy low while results remain")

   `EDFS_ASSERT_NOW(a_idle_index, clock, reset, rsp_valid && rsp_kind == edfs_pkg::KIND_IDLE, rsp_task_index_res == 3'd0, "idle beat with a task index")

endmodule

bind edf_periodic_task_scheduler_core edfs_checker u_edfs_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_mode           (req_mode),
   .rsp_valid          (rsp_valid),
   .rsp_kind           (rsp_kind),
   .rsp_task_index_res (rsp_task_index_res),
   .rsp_last           (rsp_last)
);
